@@ src/bbw_pkg.sv @@
`default_nettype none

package bbw_pkg;

    // field widths of the stream items
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned VALUE_W  = 11;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned BYTE_W   = 8;

    // packed widths of the stream buses
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 56;

    // command codes
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_FLIP      = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_REWIND    = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_SETMARK   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_RESET     = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_SETPOS    = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_ADVANCE   = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_SETLIMIT  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_REMAINING = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_COMPACT   = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_GET       = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_PUT       = 4'd11;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LIMIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_MARK = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_GET     = 3'b010,
        ST_COMPACT = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ src/bbw_ram.sv @@
`default_nettype none

module bbw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/byte_buffer_window_engine.sv @@
`default_nettype none

// Byte buffer with a position/limit window and an optional mark over a
// MAX_CAPACITY-byte store held in a single synchronous RAM. Commands enter
// on s_tdata and each one yields exactly one result on m_tdata. Pointer
// commands and put may follow back to back; get passes through a second
// state while the registered read port of the store returns its byte. Compact
// copies the window down to index 0 through the same RAM, one byte read and
// one byte written per cycle, so it holds s_tready low from its transfer
// until the last byte is written. Writing the capacity
// register resets the window (position 0, limit = min(capacity,
// MAX_CAPACITY), no mark) and must only be done while no command is in
// flight. Bytes never written read back as undefined.
module byte_buffer_window_engine #(
    parameter int unsigned MAX_CAPACITY = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // [3:0] opcode, [14:4] operand_value, [15] zero
    input  wire logic [bbw_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [1:0] status, [9:2] read_byte, [20:10] position_out, [31:21] limit_out,
    // [32] mark_set, [43:33] mark_out, [54:44] remaining, [55] zero
    output logic [bbw_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [bbw_pkg::VALUE_W-1:0]        cfg_wdata
);

    localparam int unsigned AW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int unsigned VW = bbw_pkg::VALUE_W;
    localparam int unsigned BW = bbw_pkg::BYTE_W;
    localparam logic [VW-1:0] RESET_LIMIT =
        VW'((MAX_CAPACITY < 1024) ? MAX_CAPACITY : 1024);

    bbw_pkg::state_t state_reg, state_next;

    logic [VW-1:0] cap_reg, cap_next;
    logic [VW-1:0] pos_reg, pos_next;
    logic [VW-1:0] lim_reg, lim_next;
    logic [VW-1:0] mark_reg, mark_next;
    logic          mark_valid_reg, mark_valid_next;

    // compact engine
    logic [VW-1:0] src_reg, src_next;
    logic [VW-1:0] dst_reg, dst_next;
    logic [VW-1:0] left_reg, left_next;
    logic          wr_pend_reg, wr_pend_next;
    logic [VW-1:0] wr_addr_reg, wr_addr_next;

    // result register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [bbw_pkg::STATUS_W-1:0] o_status_reg;
    logic [BW-1:0]               o_byte_reg;
    logic [VW-1:0]               o_pos_reg;
    logic [VW-1:0]               o_lim_reg;
    logic                        o_mark_set_reg;
    logic [VW-1:0]               o_mark_reg;

    logic [bbw_pkg::OPCODE_W-1:0] opcode;
    logic [VW-1:0]                operand_value;
    logic                         accept;
    logic                         out_free;
    logic [VW-1:0]                eff_cap;
    logic [VW-1:0]                cfg_eff_cap;
    logic [bbw_pkg::STATUS_W-1:0] status;
    logic                         load_out;
    logic                         out_now;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    // input unpacking and handshake
    assign opcode        = s_tdata[3:0];
    assign operand_value = s_tdata[14:4];
    assign out_free      = !m_tvalid_reg || m_tready;
    assign s_tready      = out_free && (state_reg == bbw_pkg::ST_IDLE);
    assign accept        = s_tvalid && s_tready;

    // effective capacity, saturated to the store size
    assign eff_cap = (32'(cap_reg) > MAX_CAPACITY) ? VW'(MAX_CAPACITY) : cap_reg;
    assign cfg_eff_cap = (32'(cfg_wdata) > MAX_CAPACITY) ? VW'(MAX_CAPACITY) : cfg_wdata;

    // command decode and window update
    always_comb
    begin
        logic [VW:0]   adv_sum;
        logic [VW-1:0] win_len;
        logic          get_fail;

        adv_sum  = {1'b0, pos_reg} + {1'b0, operand_value};
        win_len  = lim_reg - pos_reg;
        get_fail = (pos_reg >= lim_reg) || (32'(pos_reg) >= MAX_CAPACITY);

        state_next      = state_reg;
        cap_next        = cap_reg;
        pos_next        = pos_reg;
        lim_next        = lim_reg;
        mark_next       = mark_reg;
        mark_valid_next = mark_valid_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        left_next       = left_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        status          = bbw_pkg::STAT_OK;
        load_out        = 1'b0;
        out_now         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = AW'(pos_reg);
        ram_wdata       = operand_value[BW-1:0];
        ram_re          = 1'b0;
        ram_raddr       = AW'(pos_reg);

        if (cfg_we)
        begin
            cap_next        = cfg_wdata;
            pos_next        = '0;
            lim_next        = cfg_eff_cap;
            mark_next       = '0;
            mark_valid_next = 1'b0;
        end

        case (state_reg)
            bbw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    out_now  = 1'b1;
                    case (opcode)
                        bbw_pkg::OP_CLEAR:
                        begin
                            pos_next        = '0;
                            lim_next        = eff_cap;
                            mark_valid_next = 1'b0;
                        end
                        bbw_pkg::OP_FLIP:
                        begin
                            lim_next        = pos_reg;
                            pos_next        = '0;
                            mark_valid_next = 1'b0;
                        end
                        bbw_pkg::OP_REWIND:
                        begin
                            pos_next        = '0;
                            mark_valid_next = 1'b0;
                        end
                        bbw_pkg::OP_SETMARK:
                        begin
                            mark_next       = pos_reg;
                            mark_valid_next = 1'b1;
                        end
                        bbw_pkg::OP_RESET:
                        begin
                            if (!mark_valid_reg)
                            begin
                                status = bbw_pkg::STAT_NO_MARK;
                            end
                            else
                            begin
                                pos_next = mark_reg;
                            end
                        end
                        bbw_pkg::OP_SETPOS:
                        begin
                            if (operand_value > lim_reg)
                            begin
                                status = bbw_pkg::STAT_LIMIT;
                            end
                            else
                            begin
                                pos_next = operand_value;
                            end
                        end
                        bbw_pkg::OP_ADVANCE:
                        begin
                            if (adv_sum > {1'b0, lim_reg})
                            begin
                                status = bbw_pkg::STAT_LIMIT;
                            end
                            else
                            begin
                                pos_next = adv_sum[VW-1:0];
                            end
                        end
                        bbw_pkg::OP_SETLIMIT:
                        begin
                            if (operand_value > eff_cap)
                            begin
                                status = bbw_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                lim_next = operand_value;
                                if (pos_reg > operand_value)
                                begin
                                    pos_next = operand_value;
                                end
                            end
                        end
                        bbw_pkg::OP_COMPACT:
                        begin
                            pos_next        = win_len;
                            lim_next        = eff_cap;
                            mark_valid_next = 1'b0;
                            if ((pos_reg != '0) && (win_len != '0))
                            begin
                                src_next   = pos_reg;
                                dst_next   = '0;
                                left_next  = win_len;
                                out_now    = 1'b0;
                                state_next = bbw_pkg::ST_COMPACT;
                            end
                        end
                        bbw_pkg::OP_GET:
                        begin
                            if (get_fail)
                            begin
                                status = bbw_pkg::STAT_LIMIT;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                pos_next   = pos_reg + VW'(1);
                                out_now    = 1'b0;
                                state_next = bbw_pkg::ST_GET;
                            end
                        end
                        bbw_pkg::OP_PUT:
                        begin
                            if (operand_value[VW-1:BW] != '0)
                            begin
                                status = bbw_pkg::STAT_RANGE;
                            end
                            else if (get_fail)
                            begin
                                status = bbw_pkg::STAT_LIMIT;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                pos_next = pos_reg + VW'(1);
                            end
                        end
                        default:
                        begin
                            // remaining and unused codes only report the window
                        end
                    endcase
                    // the mark never lies above the position; this drops it
                    // where a command moves the position below it
                    if (mark_valid_next && (mark_next > pos_next))
                    begin
                        mark_valid_next = 1'b0;
                    end
                    if (!mark_valid_next)
                    begin
                        mark_next = '0;
                    end
                end
            end
            bbw_pkg::ST_GET:
            begin
                state_next = bbw_pkg::ST_IDLE;
            end
            bbw_pkg::ST_COMPACT:
            begin
                // read stage: fetch the next source byte
                if (left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = AW'(src_reg);
                    src_next     = src_reg + VW'(1);
                    dst_next     = dst_reg + VW'(1);
                    left_next    = left_reg - VW'(1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = dst_reg;
                end
                else if (!wr_pend_reg)
                begin
                    state_next = bbw_pkg::ST_IDLE;
                end
                // write stage: store the byte fetched by the previous read stage
                if (wr_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(wr_addr_reg);
                    ram_wdata = ram_rdata;
                end
            end
            default:
            begin
                state_next = bbw_pkg::ST_IDLE;
            end
        endcase

        // result valid tracking
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_now)
        begin
            m_tvalid_next = 1'b1;
        end
        if (state_reg == bbw_pkg::ST_GET)
        begin
            m_tvalid_next = 1'b1;
        end
        if ((state_reg == bbw_pkg::ST_COMPACT) && (left_reg == '0) && !wr_pend_reg)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bbw_pkg::ST_IDLE;
            cap_reg        <= VW'(1024);
            pos_reg        <= '0;
            lim_reg        <= RESET_LIMIT;
            mark_reg       <= '0;
            mark_valid_reg <= 1'b0;
            src_reg        <= '0;
            dst_reg        <= '0;
            left_reg       <= '0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            pos_reg        <= pos_next;
            lim_reg        <= lim_next;
            mark_reg       <= mark_next;
            mark_valid_reg <= mark_valid_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            left_reg       <= left_next;
            wr_pend_reg    <= wr_pend_next;
            wr_addr_reg    <= wr_addr_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_status_reg   <= status;
            o_byte_reg     <= '0;
            o_pos_reg      <= pos_next;
            o_lim_reg      <= lim_next;
            o_mark_set_reg <= mark_valid_next;
            o_mark_reg     <= mark_next;
        end
        else if (state_reg == bbw_pkg::ST_GET)
        begin
            o_byte_reg <= ram_rdata;
        end
    end

    // byte store
    bbw_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, o_lim_reg - o_pos_reg, o_mark_reg, o_mark_set_reg,
                       o_lim_reg, o_pos_reg, o_byte_reg, o_status_reg};

`ifndef SYNTH
    // window ordering holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= lim_reg))
        else $error("position above limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        mark_valid_reg |-> (mark_reg <= pos_reg))
        else $error("mark above position");

    // a get result is valid in the cycle after the ST_GET state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbw_pkg::ST_GET) |=> m_tvalid_reg)
        else $error("get result not delivered");

    // compact writes only happen while compacting
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == bbw_pkg::ST_COMPACT))
        else $error("stray compact write");

    // a finished compact leaves no copy outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bbw_pkg::ST_COMPACT) && (state_next == bbw_pkg::ST_IDLE))
        |-> ((left_reg == '0) && !wr_pend_reg))
        else $error("compact ended early");
`endif

endmodule

`default_nettype wire
